@@ hw/rtl/cfpr_pkg.sv @@
// Package for the framed packet receiver: transaction types, frame constants
// and the byte-wide CRC-16 update. No dependencies.
`default_nettype none

package cfpr_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_BYTES = 64;
	localparam int SLOT_W     = 3;
	localparam int OFFSET_W   = 6;

	localparam logic [7:0]  SYNC_BYTE    = 8'hFE;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'h8408;
	localparam logic [6:0]  HEADER_BYTES = 7'd4;
	localparam logic [7:0]  MAX_LENGTH   = 8'(SLOT_BYTES - 6);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

	typedef struct packed {
		logic [7:0]        rx_byte;
		logic [SLOT_W-1:0] consumer_slot;
	} in_item_t;

	typedef struct packed {
		logic                store_valid;
		logic [SLOT_W-1:0]   store_slot;
		logic [OFFSET_W-1:0] store_offset;
		logic [7:0]          store_byte;
		logic                packet_done;
		logic [SLOT_W-1:0]   done_slot;
		logic [15:0]         packet_crc;
		logic [SLOT_W-1:0]   newest_slot;
		logic                overrun;
	} out_item_t;

	// Reflected CCITT CRC-16, one byte, LSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cfpr_deframer.sv @@
// Frame parser and slot bookkeeping: byte counter, length, running CRC,
// receive and newest slot, overrun flag. Depends on cfpr_pkg.
`default_nettype none

module cfpr_deframer import cfpr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_item_t  item,
	output out_item_t      res
);

	logic [OFFSET_W-1:0] count_q, count_n;
	logic [OFFSET_W-1:0] length_q, length_n;
	logic [15:0]         crc_q, crc_n;
	logic [SLOT_W-1:0]   receive_q, receive_n;
	logic [SLOT_W-1:0]   tail_q, tail_n;
	logic                overrun_q, overrun_n;

	logic [OFFSET_W-1:0] length_eff;
	logic [15:0]         crc_cur;
	logic [6:0]          limit;
	logic                store;

	always_comb begin
		count_n    = count_q;
		length_n   = length_q;
		crc_n      = crc_q;
		receive_n  = receive_q;
		tail_n     = tail_q;
		overrun_n  = overrun_q;
		store      = 1'b0;
		res        = '0;
		// The length byte is checked and consumed in the same cycle it arrives.
		length_eff = (count_q == OFFSET_W'(1)) ? item.rx_byte[OFFSET_W-1:0] : length_q;
		crc_cur    = (count_q == OFFSET_W'(1)) ? CRC_INIT : crc_q;
		limit      = {1'b0, length_eff} + HEADER_BYTES;

		if (count_q == '0) begin
			store = (item.rx_byte == SYNC_BYTE);
		end else if (count_q == OFFSET_W'(1) && item.rx_byte > MAX_LENGTH) begin
			count_n = '0;
		end else begin
			length_n = length_eff;
			if ({1'b0, count_q} < limit) begin
				crc_n = crc16_byte(crc_cur, item.rx_byte);
				store = 1'b1;
			end else if ({1'b0, count_q} == limit) begin
				if (item.rx_byte == crc_cur[7:0]) begin
					store = 1'b1;
				end else begin
					count_n = '0;
				end
			end else begin
				if (item.rx_byte == crc_cur[15:8]) begin
					res.packet_done = 1'b1;
					res.done_slot   = receive_q;
					res.packet_crc  = crc_cur;
					tail_n          = receive_q;
					receive_n       = (receive_q == SLOT_LAST) ? '0 : receive_q + SLOT_W'(1);
					if (receive_n == item.consumer_slot) begin
						overrun_n = 1'b1;
					end
				end
				count_n = '0;
			end
		end

		if (store) begin
			res.store_valid  = 1'b1;
			res.store_slot   = receive_q;
			res.store_offset = count_q;
			res.store_byte   = item.rx_byte;
			count_n          = count_q + OFFSET_W'(1);
		end
		res.newest_slot = tail_n;
		res.overrun     = overrun_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			length_q  <= '0;
			crc_q     <= CRC_INIT;
			receive_q <= '0;
			tail_q    <= SLOT_LAST;
			overrun_q <= 1'b0;
		end else if (step) begin
			count_q   <= count_n;
			length_q  <= length_n;
			crc_q     <= crc_n;
			receive_q <= receive_n;
			tail_q    <= tail_n;
			overrun_q <= overrun_n;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/crc_framed_packet_receiver.sv @@
// Top level of the framed packet receiver: input register, parser, result register.
// Depends on cfpr_pkg and cfpr_deframer.
`default_nettype none

// Takes one received byte per transaction and returns one result per byte:
// a ring write (slot, offset, byte) for stored frame bytes, a completion with
// slot and CRC when a frame passes its CRC-16 check, plus the newest completed
// slot and the sticky overrun flag. Frames are sync 0xFE, length (at most
// SLOT_BYTES-6), two header bytes, payload, CRC low then high. A byte passes
// through the input register, then the result register, to its result, and one byte
// is accepted every cycle while the block does not stall; the byte-wide CRC update and
// the frame counter lie between the two registers. The block stalls input only while
// its result register is full and held.
module crc_framed_packet_receiver import cfpr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      byte_valid,
	output logic           byte_stall,
	input  wire in_item_t  byte_item,
	output logic           result_valid,
	input  wire logic      result_stall,
	output out_item_t      result_item
);

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_s2;
	logic      valid_s2;
	out_item_t res;
	logic      advance;

	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	cfpr_deframer u_deframer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (byte_valid && !byte_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (!valid_s2 || !result_stall) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
		if (advance) begin
			result_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result_item  = result_s2;

endmodule

`default_nettype wire

@@ hw/rtl/cfpr_checker.sv @@
// Port-level checks for the framed packet receiver, bound to the top level.
// Depends on cfpr_pkg.
`default_nettype none

module cfpr_checker import cfpr_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      result_valid,
	input wire logic      result_stall,
	input wire out_item_t result_item
);

	logic overrun_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overrun_seen_q <= 1'b0;
		end else if (result_valid && !result_stall && result_item.overrun) begin
			overrun_seen_q <= 1'b1;
		end
	end

	// Once a transaction has reported overrun, every later one does too.
	a_overrun_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && overrun_seen_q |-> result_item.overrun)
		else $error("overrun flag dropped");

	// A completed frame becomes the newest slot in the same transaction.
	a_done_newest: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.packet_done |->
			result_item.newest_slot == result_item.done_slot && !result_item.store_valid)
		else $error("completion inconsistent with newest slot or store");

	// Write fields are zero when nothing is written.
	a_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.store_valid |->
			result_item.store_slot == '0 && result_item.store_offset == '0 &&
			result_item.store_byte == '0)
		else $error("store fields nonzero without a write");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("stalled result changed");

endmodule

bind crc_framed_packet_receiver cfpr_checker u_cfpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_item  (result_item)
);

`default_nettype wire

@@ test/crc_framed_packet_receiver_tb.sv @@
// Self-checking testbench for crc_framed_packet_receiver: framed byte streams in, ring writes
// and frame completions out, checked against a predictor kept in this file.
// Depends on cfpr_pkg and the receiver RTL.
`timescale 1ns / 100ps

module crc_framed_packet_receiver_tb;
	import cfpr_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 11;
	localparam int ITEM_TARGET  = 860;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 10;

	typedef enum logic [1:0] {FRAME_GOOD, FRAME_BAD_LOW, FRAME_BAD_HIGH} frame_fault_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD}
		stall_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result_item;

	// Predictor state.
	logic [OFFSET_W-1:0] frame_pos = '0;
	logic [OFFSET_W-1:0] frame_len = '0;
	logic [15:0]         crc_run = CRC_INIT;
	logic [SLOT_W-1:0]   fill_slot = '0;
	logic [SLOT_W-1:0]   newest_seen = SLOT_LAST;
	logic                overrun_seen = 1'b0;

	out_item_t   expected_results[$];
	logic [7:0]  frame_body[$];
	int          cycle_count = 0;
	int          fail_count = 0;
	int          results_checked = 0;
	int          bytes_sent = 0;
	int          frame_items = 0;
	int          frames_completed = 0;
	int          frames_rejected = 0;
	int          burst_left = 0;
	bit          sender_paced = 1'b1;
	int          hold_asked = 0;
	int          hold_taken = 0;
	int          hold_left = 0;
	int          pattern_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	crc_framed_packet_receiver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] v;
		v = acc ^ {8'h00, data};
		repeat (8) v = (v >> 1) ^ (v[0] ? CRC_POLY : 16'h0000);
		return v;
	endfunction

	// Advances the deframer state by one byte and returns the result it must produce.
	function automatic out_item_t predict_result(input logic [7:0] b,
			input logic [SLOT_W-1:0] cons);
		out_item_t r;
		int        crc_pos;
		bit        keep;
		r = '0;
		keep = 1'b0;
		crc_pos = int'(HEADER_BYTES) + int'(frame_len);
		if (frame_pos == 0) begin
			keep = (b == SYNC_BYTE);
		end else if (frame_pos == 1 && b > MAX_LENGTH) begin
			frame_pos = '0;
			frames_rejected++;
		end else begin
			if (frame_pos == 1) begin
				frame_len = b[OFFSET_W-1:0];
				crc_run = CRC_INIT;
				crc_pos = int'(HEADER_BYTES) + int'(b);
			end
			if (int'(frame_pos) < crc_pos) begin
				crc_run = crc16_next(crc_run, b);
				keep = 1'b1;
			end else if (int'(frame_pos) == crc_pos) begin
				if (b == crc_run[7:0]) begin
					keep = 1'b1;
				end else begin
					frame_pos = '0;
					frames_rejected++;
				end
			end else begin
				if (b == crc_run[15:8]) begin
					r.packet_done = 1'b1;
					r.done_slot = fill_slot;
					r.packet_crc = crc_run;
					newest_seen = fill_slot;
					fill_slot = (fill_slot == SLOT_LAST) ? '0 : fill_slot + 1'b1;
					if (fill_slot == cons)
						overrun_seen = 1'b1;
					frames_completed++;
				end else begin
					frames_rejected++;
				end
				frame_pos = '0;
			end
		end
		if (keep) begin
			r.store_valid = 1'b1;
			r.store_slot = fill_slot;
			r.store_offset = frame_pos;
			r.store_byte = b;
			frame_pos = frame_pos + 1'b1;
		end
		r.newest_slot = newest_seen;
		r.overrun = overrun_seen;
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] any_slot();
		return SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
	endfunction

	task automatic pace_sender();
		int gap;
		if (!sender_paced)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 9);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic [SLOT_W-1:0] cons);
		in_item_t it;
		it.rx_byte = b;
		it.consumer_slot = cons;
		byte_item <= it;
		byte_valid <= 1'b1;
		do @(posedge clk); while (byte_stall !== 1'b0);
		expected_results.push_back(predict_result(b, cons));
		bytes_sent++;
		pace_sender();
	endtask

	// Sends sync, the bytes queued in frame_body, then the CRC low and high bytes.
	// With collide set, the consumer sits on the slot that a good frame advances to.
	task automatic send_frame(input frame_fault_t fault, input bit collide);
		logic [15:0]       crc;
		logic [SLOT_W-1:0] next_slot;
		logic [SLOT_W-1:0] cons;
		crc = CRC_INIT;
		foreach (frame_body[i])
			crc = crc16_next(crc, frame_body[i]);
		send_byte(SYNC_BYTE, any_slot());
		foreach (frame_body[i])
			send_byte(frame_body[i], any_slot());
		if (fault == FRAME_BAD_LOW)
			send_byte(crc[7:0] ^ 8'($urandom_range(1, 255)), any_slot());
		else
			send_byte(crc[7:0], any_slot());
		next_slot = (fill_slot == SLOT_LAST) ? '0 : fill_slot + 1'b1;
		cons = collide ? next_slot : next_slot + SLOT_W'($urandom_range(1, SLOT_COUNT - 1));
		if (fault == FRAME_BAD_HIGH)
			send_byte(crc[15:8] ^ 8'($urandom_range(1, 255)), cons);
		else
			send_byte(crc[15:8], cons);
		frame_items += frame_body.size() + 3;
	endtask

	task automatic build_random_body(input int len);
		frame_body.delete();
		frame_body.push_back(8'(len));
		repeat (len + 2) frame_body.push_back(8'($urandom_range(0, 255)));
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(0, 8);
		if (r == 7)
			return ($urandom_range(0, 1) == 0) ? 0 : int'(MAX_LENGTH);
		return $urandom_range(0, int'(MAX_LENGTH));
	endfunction

	task automatic wait_drained();
		byte_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic test_directed_frames();
		// Bytes ignored while hunting for sync.
		send_byte(8'h00, 3'd0);
		send_byte(8'hFF, 3'd7);
		send_byte(SYNC_BYTE - 8'd1, 3'd5);
		frame_body = '{8'h00, 8'h00, 8'hFF};
		send_frame(FRAME_GOOD, 1'b0);
		// Length one past the limit is refused.
		send_byte(SYNC_BYTE, 3'd2);
		send_byte(MAX_LENGTH + 8'd1, 3'd2);
		// A sync value in the length position is refused and not taken as a new sync.
		send_byte(SYNC_BYTE, 3'd1);
		send_byte(SYNC_BYTE, 3'd6);
		send_byte(8'h00, 3'd4);
		frame_body = '{8'h01, 8'hAA, 8'h55, 8'h80};
		send_frame(FRAME_BAD_LOW, 1'b0);
		frame_body = '{8'h00, 8'h12, 8'h34};
		send_frame(FRAME_BAD_HIGH, 1'b0);
	endtask

	task automatic test_longest_frames();
		frame_body.delete();
		frame_body.push_back(MAX_LENGTH);
		repeat (int'(MAX_LENGTH) + 2) frame_body.push_back(8'hFF);
		send_frame(FRAME_GOOD, 1'b0);
		foreach (frame_body[i])
			if (i > 0)
				frame_body[i] = 8'h00;
		send_frame(FRAME_GOOD, 1'b0);
	endtask

	// The result side holds off for a long stretch while bytes keep coming, so the
	// block fills and pushes back on its input.
	task automatic test_backpressure();
		hold_asked <= hold_asked + 1;
		sender_paced = 1'b0;
		repeat (6) begin
			build_random_body($urandom_range(0, 6));
			send_frame(FRAME_GOOD, 1'b0);
		end
		sender_paced = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int pick;
		frame_items = 0;
		while (frame_items < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				build_random_body(pick_length());
				send_frame(FRAME_GOOD, 1'b0);
			end else if (pick < 76) begin
				build_random_body(pick_length());
				send_frame(FRAME_BAD_LOW, 1'b0);
			end else if (pick < 82) begin
				build_random_body(pick_length());
				send_frame(FRAME_BAD_HIGH, 1'b0);
			end else if (pick < 90) begin
				send_byte(SYNC_BYTE, any_slot());
				send_byte(8'($urandom_range(int'(MAX_LENGTH) + 1, 255)), any_slot());
				frame_items += 2;
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), any_slot());
			end
		end
		wait_drained();
	endtask

	// The overrun flag is sticky, so this runs last.
	task automatic test_overrun();
		build_random_body($urandom_range(0, 4));
		send_frame(FRAME_GOOD, 1'b1);
		repeat (3) begin
			build_random_body($urandom_range(0, 4));
			send_frame(FRAME_GOOD, 1'b0);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_longest_frames();
		test_backpressure();
		test_random_traffic();
		test_overrun();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d bytes, checked %0d results: %0d frames completed, %0d rejected.",
			bytes_sent, results_checked, frames_completed, frames_rejected);
		$display("Included a %0d-cycle result hold, longest frames and the overrun flag.",
			HOLD_CYCLES);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("[crc_framed_packet_receiver] OK");
		else
			$display("[crc_framed_packet_receiver] ERROR");
		$finish;
	end

	// Result stall: a long hold on request, otherwise a randomly chosen pattern per stretch.
	always @(posedge clk) begin
		if (hold_asked != hold_taken) begin
			hold_taken = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(16, 96);
			end
			pattern_left--;
			case (stall_mode)
				STALL_NONE: begin
					result_stall <= 1'b0;
				end
				STALL_LIGHT: begin
					result_stall <= ($urandom_range(0, 7) == 0);
				end
				STALL_HEAVY: begin
					result_stall <= ($urandom_range(0, 1) == 0);
				end
				default: begin
					result_stall <= (cycle_count % 3 == 0);
				end
			endcase
		end
	end

	function automatic string diff_fields(input out_item_t e, input out_item_t a);
		string s;
		s = "";
		if (e.store_valid !== a.store_valid) s = {s, " store_valid"};
		if (e.store_slot !== a.store_slot) s = {s, " store_slot"};
		if (e.store_offset !== a.store_offset) s = {s, " store_offset"};
		if (e.store_byte !== a.store_byte) s = {s, " store_byte"};
		if (e.packet_done !== a.packet_done) s = {s, " packet_done"};
		if (e.done_slot !== a.done_slot) s = {s, " done_slot"};
		if (e.packet_crc !== a.packet_crc) s = {s, " packet_crc"};
		if (e.newest_slot !== a.newest_slot) s = {s, " newest_slot"};
		if (e.overrun !== a.overrun) s = {s, " overrun"};
		return s;
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		string     bad;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("Unexpected result %h at cycle %0d", result_item, cycle_count);
			end else begin
				want = expected_results.pop_front();
				bad = diff_fields(want, result_item);
				if (bad != "") begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("Result %0d mismatch in%s: expected %h, got %h",
							results_checked, bad, want, result_item);
				end
			end
			results_checked++;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
			expected_results.size());
		$display("[crc_framed_packet_receiver] ERROR");
		$finish;
	end

endmodule
